### src/pfsac_pkg.sv
// Shared constants and types for the path-following steering and acceleration controller.
`timescale 1ns / 1ps
`default_nettype none

package pfsac_pkg;

  // Field widths of the request and result items.
  localparam int SPEED_W   = 15;
  localparam int LAT_W     = 16;
  localparam int YAW_W     = 13;
  localparam int STEER_W   = 11;
  localparam int ACCEL_W   = 12;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Internal arithmetic widths.
  localparam int LC_W     = 16;  // look-ahead distance, up to 49452 cm
  localparam int LATD_W   = 17;  // lateral deviation minus offset
  localparam int PROD_W   = 30;  // heading error times look-ahead
  localparam int LAT100_W = 24;  // lateral deviation times 100
  localparam int SUM_W    = 31;  // numerator before the gain
  localparam int LC2_W    = 32;  // look-ahead squared
  localparam int DVD_W    = 41;  // numerator magnitude times 800
  localparam int CMP_W    = 44;  // divisor shifted by up to eleven places
  localparam int QUO_W    = 12;  // quotient bits kept before clamping
  localparam int ACCR_W   = 19;  // acceleration before clamping

  // Pipeline shape: four arithmetic stages, six divider stages, one output stage.
  localparam int DIV_STAGES = 6;
  localparam int DIV_FIRST  = 4;
  localparam int NUM_STAGES = DIV_FIRST + DIV_STAGES + 1;

  // Output limits and fixed gains.
  localparam int STEER_LIMIT = 600;
  localparam int ACCEL_LIMIT = 2000;
  localparam int LC_BASE     = 300;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_USE_EXT    = 2'd0,
    REG_EXT_SPEED  = 2'd1,
    REG_LAT_OFFSET = 2'd2
  } cfg_reg_e_t;

  // Results that are ready early and ride alongside the divider.
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic signed [ACCEL_W-1:0] accel;
    logic                      neg;
  } sidecar_t;

endpackage

`default_nettype wire

### src/path_follow_steer_accel_ctrl.sv
// Pipelined steering and acceleration command unit with an APB-style register port.
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle unless m_tready stalls the pipeline; the steering quotient is found by a six-stage
// restoring divider that settles two quotient bits per stage.
// Each stage holds its item only while the next one is full and stalled, so bubbles close up.
// Reset (rst, synchronous) empties the pipeline and clears all three registers to zero.

module path_follow_steer_accel_ctrl (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // s_tdata: ego_speed[14:0], lateral_error_raw[30:15], heading_error[43:31],
  // path_speed[58:44], zero padding above
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [pfsac_pkg::IN_TDATA_W-1:0]     s_tdata,
  // m_tdata: steer_command[10:0], speed_command[25:11], accel_command[37:26],
  // zero padding above
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [pfsac_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pfsac_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [pfsac_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pfsac_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                      pready
);

  import pfsac_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  // Configuration registers.
  logic                      use_ext;
  logic signed [SPEED_W-1:0] ext_speed;
  logic signed [LAT_W-1:0]   lat_offset;
  logic                      cfg_wr;
  cfg_reg_e_t                cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e_t'(paddr[3:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_ext    <= 1'b0;
      ext_speed  <= '0;
      lat_offset <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_USE_EXT:    use_ext    <= pwdata[0];
        REG_EXT_SPEED:  ext_speed  <= pwdata[SPEED_W-1:0];
        REG_LAT_OFFSET: lat_offset <= pwdata[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_sel)
      REG_USE_EXT:    prdata = {{(APB_DATA_W-1){1'b0}}, use_ext};
      REG_EXT_SPEED:  prdata = {{(APB_DATA_W-SPEED_W){1'b0}}, ext_speed};
      REG_LAT_OFFSET: prdata = {{(APB_DATA_W-LAT_W){1'b0}}, lat_offset};
      default:        prdata = '0;
    endcase
  end

  // Stage occupancy and advance chain.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  assign adv[LAST] = !vld[LAST] || m_tready;
  for (genvar k = 0; k < LAST; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= (k == 0) ? s_tvalid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Request fields.
  logic signed [SPEED_W-1:0] in_ego;
  logic signed [LAT_W-1:0]   in_lat;
  logic signed [YAW_W-1:0]   in_yaw;
  logic signed [SPEED_W-1:0] in_path;

  assign in_ego  = s_tdata[14:0];
  assign in_lat  = s_tdata[30:15];
  assign in_yaw  = s_tdata[43:31];
  assign in_path = s_tdata[58:44];

  // Stage 1: look-ahead distance, offset deviation, speed target and acceleration.
  logic [SPEED_W-1:0]         abs_v;
  logic [LC_W-1:0]            lc_c;
  logic signed [LATD_W-1:0]   latd_c;
  logic signed [SPEED_W-1:0]  target_c;
  logic signed [SPEED_W:0]    diff_c;
  logic signed [ACCR_W-1:0]   diff_x;
  logic signed [ACCR_W-1:0]   acc_raw;
  logic signed [ACCEL_W-1:0]  acc_c;

  assign abs_v    = in_ego[SPEED_W-1] ? (~in_ego + 1'b1) : in_ego;
  assign lc_c     = ({1'b0, abs_v} << 1) + {1'b0, abs_v} + LC_W'(LC_BASE);
  assign latd_c   = {in_lat[LAT_W-1], in_lat} - {lat_offset[LAT_W-1], lat_offset};
  assign target_c = use_ext ? ext_speed : in_path;
  assign diff_c   = {in_ego[SPEED_W-1], in_ego} - {target_c[SPEED_W-1], target_c};
  assign diff_x   = {{(ACCR_W-SPEED_W-1){diff_c[SPEED_W]}}, diff_c};
  assign acc_raw  = -((diff_x <<< 2) + diff_x);

  always_comb begin
    if (acc_raw > ACCR_W'(ACCEL_LIMIT)) begin
      acc_c = ACCEL_W'(ACCEL_LIMIT);
    end else if (acc_raw < -ACCR_W'(ACCEL_LIMIT)) begin
      acc_c = -ACCEL_W'(ACCEL_LIMIT);
    end else begin
      acc_c = acc_raw[ACCEL_W-1:0];
    end
  end

  logic [LC_W-1:0]          s1_lc;
  logic signed [LATD_W-1:0] s1_lat;
  logic signed [YAW_W-1:0]  s1_yaw;
  sidecar_t                 side [LAST];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_lc         <= lc_c;
      s1_lat        <= latd_c;
      s1_yaw        <= in_yaw;
      side[0].speed <= target_c;
      side[0].accel <= acc_c;
      side[0].neg   <= 1'b0;
    end
  end

  // Stage 2: the three products.
  logic signed [PROD_W-1:0]   s2_prod;
  logic signed [LAT100_W-1:0] s2_lat100;
  logic [LC2_W-1:0]           s2_lc2;
  logic signed [LC_W:0]       lc_s;

  assign lc_s = {1'b0, s1_lc};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_prod   <= s1_yaw * lc_s;
      s2_lat100 <= s1_lat * LAT100_W'(100);
      s2_lc2    <= s1_lc * s1_lc;
    end
  end

  // Stage 3: numerator before the gain.
  logic signed [SUM_W-1:0] s3_sum;
  logic [LC2_W-1:0]        s3_lc2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_sum <= {{(SUM_W-LAT100_W){s2_lat100[LAT100_W-1]}}, s2_lat100}
              + {{(SUM_W-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
      s3_lc2 <= s2_lc2;
    end
  end

  // Stage 4: sign of the quotient and dividend magnitude times 800.
  logic [SUM_W-1:0] abs_sum;
  logic [DVD_W-1:0] abs_ext;
  logic [DVD_W-1:0] s4_mag;
  logic [LC2_W-1:0] s4_lc2;

  assign abs_sum = s3_sum[SUM_W-1] ? (~s3_sum + 1'b1) : s3_sum;
  assign abs_ext = {{(DVD_W-SUM_W){1'b0}}, abs_sum};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_mag <= (abs_ext << 9) + (abs_ext << 8) + (abs_ext << 5);
      s4_lc2 <= s3_lc2;
    end
  end

  // Sidecar moves along with the arithmetic; the sign is filled in at stage 4.
  for (genvar k = 1; k < LAST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        side[k].speed <= side[k-1].speed;
        side[k].accel <= side[k-1].accel;
        side[k].neg   <= (k == DIV_FIRST - 1) ? (s3_sum > 0) : side[k-1].neg;
      end
    end
  end

  // Stages 5 to 10: restoring divider, two quotient bits per stage, MSB first.
  logic [DVD_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];
  logic [LC2_W-1:0] dvs_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int SH0 = QUO_W - 1 - 2 * j;
    localparam int SH1 = SH0 - 1;

    logic [DVD_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [LC2_W-1:0] dvs_in;
    logic [CMP_W-1:0] dsh0;
    logic [CMP_W-1:0] dsh1;
    logic [CMP_W-1:0] diff0;
    logic [CMP_W-1:0] diff1;
    logic [DVD_W-1:0] rem_mid;
    logic [DVD_W-1:0] rem_out;
    logic             ge0;
    logic             ge1;

    if (j == 0) begin : g_first
      assign rem_in = s4_mag;
      assign quo_in = '0;
      assign dvs_in = s4_lc2;
    end else begin : g_rest
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign dvs_in = dvs_r[j-1];
    end

    // First trial subtraction.
    assign dsh0    = {{(CMP_W-LC2_W){1'b0}}, dvs_in} << SH0;
    assign diff0   = {{(CMP_W-DVD_W){1'b0}}, rem_in} - dsh0;
    assign ge0     = {{(CMP_W-DVD_W){1'b0}}, rem_in} >= dsh0;
    assign rem_mid = ge0 ? diff0[DVD_W-1:0] : rem_in;

    // Second trial subtraction.
    assign dsh1    = {{(CMP_W-LC2_W){1'b0}}, dvs_in} << SH1;
    assign diff1   = {{(CMP_W-DVD_W){1'b0}}, rem_mid} - dsh1;
    assign ge1     = {{(CMP_W-DVD_W){1'b0}}, rem_mid} >= dsh1;
    assign rem_out = ge1 ? diff1[DVD_W-1:0] : rem_mid;

    always_ff @(posedge clk) begin
      if (adv[DIV_FIRST + j]) begin
        rem_r[j] <= rem_out;
        quo_r[j] <= {quo_in[QUO_W-3:0], ge0, ge1};
        dvs_r[j] <= dvs_in;
      end
    end
  end

  // Stage 11: clamp, sign and result register.
  logic [QUO_W-1:0]          quo_fin;
  logic [STEER_W-2:0]        steer_mag;
  logic signed [STEER_W-1:0] steer_c;
  logic signed [STEER_W-1:0] out_steer;
  logic signed [SPEED_W-1:0] out_speed;
  logic signed [ACCEL_W-1:0] out_accel;

  assign quo_fin   = quo_r[DIV_STAGES-1];
  assign steer_mag = (quo_fin > QUO_W'(STEER_LIMIT)) ? (STEER_W-1)'(STEER_LIMIT)
                                                     : quo_fin[STEER_W-2:0];
  assign steer_c   = side[LAST-1].neg ? -{1'b0, steer_mag} : {1'b0, steer_mag};

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      out_steer <= steer_c;
      out_speed <= side[LAST-1].speed;
      out_accel <= side[LAST-1].accel;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-STEER_W-SPEED_W-ACCEL_W){1'b0}},
                    out_accel, out_speed, out_steer};

  // Checks on the datapath limits and the advance chain.
  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_steer <= STEER_W'(STEER_LIMIT)) && (out_steer >= -STEER_W'(STEER_LIMIT)))
    else $error("steering command outside its limit");

  a_accel_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_accel <= ACCEL_W'(ACCEL_LIMIT)) && (out_accel >= -ACCEL_W'(ACCEL_LIMIT)))
    else $error("acceleration command outside its limit");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the result stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted request did not enter the first stage");

endmodule

`default_nettype wire
